### hw/rtl/sgd_momentum_update_core_macros.svh
// Assertion macros used by the checker file of the update core.
`ifndef SGD_MOMENTUM_UPDATE_CORE_MACROS_SVH
`define SGD_MOMENTUM_UPDATE_CORE_MACROS_SVH

// Implication into the next cycle, off while reset is high.
`define SGD_MU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication, off while reset is high.
`define SGD_MU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle that also watches reset itself.
`define SGD_MU_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sgd_mu_pkg.sv
// Shared types, constants and fixed-point helpers of the SGD momentum update core.
package sgd_mu_pkg;

  localparam int unsigned VELOCITY_DEPTH_DEFAULT = 4096;

  localparam int INDEX_W     = 12;
  localparam int DATA_W      = 32;
  localparam int FACTOR_W    = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_RATE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOMENTUM_FACTOR  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPENING_FACTOR = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_FACTOR     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NESTEROV_ENABLE  = 3'd4;

  localparam logic [FACTOR_W-1:0] LEARNING_RATE_RESET = 16'd655;
  // One in Q1.16
  localparam logic [FACTOR_W:0]   FACTOR_ONE = 17'h10000;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic [FACTOR_W:0]        factor_t;

  typedef struct packed {
    logic [INDEX_W-1:0] element_index;
    fix_t               weight_value;
    fix_t               gradient_value;
  } in_item_t;

  typedef struct packed {
    fix_t new_weight;
    fix_t new_velocity;
  } out_item_t;

  localparam fix_t FIX_MAX = 32'sh7fffffff;
  localparam fix_t FIX_MIN = 32'sh80000000;

  // Clamp a sum that grew by one bit back into Q16.16.
  function automatic fix_t sat_sum(input logic signed [DATA_W:0] s);
    fix_t r;
    if (s[DATA_W] == s[DATA_W-1]) begin
      r = s[DATA_W-1:0];
    end else begin
      r = s[DATA_W] ? FIX_MIN : FIX_MAX;
    end
    return r;
  endfunction

  // Q16.16 times unsigned Q1.16: exact product, round half up, clamp.
  function automatic fix_t qmul(input fix_t a, input factor_t f);
    logic signed [DATA_W+FACTOR_W+1:0] q;
    logic signed [DATA_W+1:0]          r;
    fix_t                              res;
    q = a * $signed({1'b0, f}) + $signed((DATA_W+FACTOR_W+2)'(32768));
    r = q[DATA_W+FACTOR_W+1:FACTOR_W];
    if (r[DATA_W+1:DATA_W-1] == 3'b000 || r[DATA_W+1:DATA_W-1] == 3'b111) begin
      res = r[DATA_W-1:0];
    end else begin
      res = r[DATA_W+1] ? FIX_MIN : FIX_MAX;
    end
    return res;
  endfunction

endpackage

### hw/rtl/sgd_mu_stream_if.sv
// Valid/ready item channel with a typed payload.
interface sgd_mu_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/sgd_mu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgd_mu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/sgd_momentum_update_core.sv
// SGD momentum update core: per-element weight step with a velocity memory.
//
// One item (index, weight, gradient) enters per clock and its result (new weight,
// new velocity) comes from the last stage. Throughput is one item per cycle with
// any mix of indexes: the velocity memory is read one stage ahead of the update
// stage and a result written by the item just ahead is forwarded, so repeated
// indexes never stall. After reset the velocity memory is cleared one entry per
// cycle, all VELOCITY_DEPTH entries, while request.ready stays low; configuration
// writes are taken during that pass. When the result register holds an item that
// is not taken, the whole pipeline holds. Indexes at or above VELOCITY_DEPTH see
// a zero velocity and never write the memory. Configuration may only change
// while no item is in flight.
module sgd_momentum_update_core #(
  parameter int unsigned VELOCITY_DEPTH = sgd_mu_pkg::VELOCITY_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [sgd_mu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sgd_mu_pkg::CFG_DATA_W-1:0]   cfg_data,
  sgd_mu_stream_if.sink                       request,
  sgd_mu_stream_if.source                     result
);

  localparam int AW    = $clog2(VELOCITY_DEPTH);
  localparam int CNT_W = AW + 1;
  localparam int CW    = ((AW > sgd_mu_pkg::INDEX_W) ? AW : sgd_mu_pkg::INDEX_W) + 1;
  localparam int NSTG  = 9;

  // Configuration registers
  logic [sgd_mu_pkg::FACTOR_W-1:0] learning_rate;
  logic [sgd_mu_pkg::FACTOR_W-1:0] momentum_factor;
  logic [sgd_mu_pkg::FACTOR_W-1:0] dampening_factor;
  logic [sgd_mu_pkg::FACTOR_W-1:0] decay_factor;
  logic                            nesterov_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate    <= sgd_mu_pkg::LEARNING_RATE_RESET;
      momentum_factor  <= '0;
      dampening_factor <= '0;
      decay_factor     <= '0;
      nesterov_enable  <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        sgd_mu_pkg::REG_LEARNING_RATE:    learning_rate    <= cfg_data;
        sgd_mu_pkg::REG_MOMENTUM_FACTOR:  momentum_factor  <= cfg_data;
        sgd_mu_pkg::REG_DAMPENING_FACTOR: dampening_factor <= cfg_data;
        sgd_mu_pkg::REG_DECAY_FACTOR:     decay_factor     <= cfg_data;
        sgd_mu_pkg::REG_NESTEROV_ENABLE:  nesterov_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic                mom_on;
  sgd_mu_pkg::factor_t damp_scale;

  assign mom_on     = (momentum_factor != '0);
  assign damp_scale = sgd_mu_pkg::FACTOR_ONE - {1'b0, dampening_factor};

  // Clearing pass over the velocity memory after reset
  logic [CNT_W-1:0] clr_cnt;
  logic             clearing;

  assign clearing = (clr_cnt != CNT_W'(VELOCITY_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Pipeline control: advance everything unless the result register is stuck
  logic [NSTG:1] vld;
  logic          adv;
  logic          in_fire;

  assign adv           = !vld[NSTG] || result.ready;
  assign request.ready = adv && !clearing;
  assign in_fire       = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-1:1], in_fire};
    end
  end

  // Entry decode of the incoming index
  logic [CW-1:0] idx_ext;
  logic          in_ok;

  assign idx_ext = CW'(request.data.element_index);
  assign in_ok   = (idx_ext < CW'(VELOCITY_DEPTH));

  // Stage registers (payload, no reset)
  logic [AW-1:0]     addr1, addr2, addr3, addr4, addr5;
  logic              ok1, ok2, ok3, ok4;
  logic              wr5;
  sgd_mu_pkg::fix_t  w1, w2, w3, w4, w5, w6, w7, w8;
  sgd_mu_pkg::fix_t  g1, g2;
  sgd_mu_pkg::fix_t  wd2;
  sgd_mu_pkg::fix_t  gdec3, gdec4, gdec5, gdec6;
  sgd_mu_pkg::fix_t  gd4;
  sgd_mu_pkg::fix_t  vnew5, vnew6, vnew7, vnew8;
  sgd_mu_pkg::fix_t  mv6;
  sgd_mu_pkg::fix_t  step7;
  sgd_mu_pkg::fix_t  ls8;
  sgd_mu_pkg::out_item_t out_reg;

  // Velocity memory
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  sgd_mu_pkg::fix_t ram_wdata;
  logic             ram_re;
  logic [sgd_mu_pkg::DATA_W-1:0] ram_rdata;

  // Update stage signals
  logic             fwd;
  sgd_mu_pkg::fix_t v_old;
  sgd_mu_pkg::fix_t mv_old;
  sgd_mu_pkg::fix_t v_new;
  logic             wr4;
  sgd_mu_pkg::fix_t step_next;

  // Take the last write when the item ahead updated the same entry; the memory
  // read for this item was issued in the same cycle as that write.
  assign fwd    = vld[5] && wr5 && ok4 && (addr5 == addr4);
  assign v_old  = !ok4 ? '0 : (fwd ? vnew5 : sgd_mu_pkg::fix_t'(ram_rdata));
  assign wr4    = mom_on && ok4;
  assign mv_old = sgd_mu_pkg::qmul(v_old, {1'b0, momentum_factor});
  assign v_new  = mom_on
                ? sgd_mu_pkg::sat_sum({mv_old[sgd_mu_pkg::DATA_W-1], mv_old} +
                                      {gd4[sgd_mu_pkg::DATA_W-1], gd4})
                : v_old;

  assign ram_we    = clearing || (adv && vld[4] && wr4);
  assign ram_waddr = clearing ? clr_cnt[AW-1:0] : addr4;
  assign ram_wdata = clearing ? '0 : v_new;
  assign ram_re    = adv && vld[3];

  sgd_mu_ram #(
    .WIDTH(sgd_mu_pkg::DATA_W),
    .DEPTH(VELOCITY_DEPTH)
  ) u_velocity_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr3),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (!mom_on) begin
      step_next = gdec6;
    end else if (nesterov_enable) begin
      step_next = sgd_mu_pkg::sat_sum({gdec6[sgd_mu_pkg::DATA_W-1], gdec6} +
                                      {mv6[sgd_mu_pkg::DATA_W-1], mv6});
    end else begin
      step_next = vnew6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: capture the item
      addr1 <= idx_ext[AW-1:0];
      ok1   <= in_ok;
      w1    <= request.data.weight_value;
      g1    <= request.data.gradient_value;
      // Stage 2: weight decay product
      addr2 <= addr1;
      ok2   <= ok1;
      w2    <= w1;
      g2    <= g1;
      wd2   <= sgd_mu_pkg::qmul(w1, {1'b0, decay_factor});
      // Stage 3: decayed gradient; the memory read issues from here
      addr3 <= addr2;
      ok3   <= ok2;
      w3    <= w2;
      gdec3 <= sgd_mu_pkg::sat_sum({g2[sgd_mu_pkg::DATA_W-1], g2} +
                                   {wd2[sgd_mu_pkg::DATA_W-1], wd2});
      // Stage 4: damped gradient
      addr4 <= addr3;
      ok4   <= ok3;
      w4    <= w3;
      gdec4 <= gdec3;
      gd4   <= sgd_mu_pkg::qmul(gdec3, damp_scale);
      // Stage 5: velocity update, written back from stage 4
      addr5 <= addr4;
      wr5   <= wr4;
      w5    <= w4;
      gdec5 <= gdec4;
      vnew5 <= v_new;
      // Stage 6: look-ahead product
      w6    <= w5;
      gdec6 <= gdec5;
      vnew6 <= vnew5;
      mv6   <= sgd_mu_pkg::qmul(vnew5, {1'b0, momentum_factor});
      // Stage 7: step select
      w7    <= w6;
      vnew7 <= vnew6;
      step7 <= step_next;
      // Stage 8: learning-rate product
      w8    <= w7;
      vnew8 <= vnew7;
      ls8   <= sgd_mu_pkg::qmul(step7, {1'b0, learning_rate});
      // Result register
      out_reg.new_weight   <= sgd_mu_pkg::sat_sum({w8[sgd_mu_pkg::DATA_W-1], w8} -
                                                  {ls8[sgd_mu_pkg::DATA_W-1], ls8});
      out_reg.new_velocity <= vnew8;
    end
  end

  assign result.valid = vld[NSTG];
  assign result.data  = out_reg;

endmodule

### hw/rtl/sgd_mu_checker.sv
// Port-level checker of the update core, bound to the top level.
`include "sgd_momentum_update_core_macros.svh"

module sgd_mu_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sgd_mu_pkg::out_item_t out_data
);

  // Reset empties the pipeline and starts the memory clearing pass.
  `SGD_MU_ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, rst, !out_valid && !in_ready, "reset did not quiet the ports")

  // A result that is not taken stays put.
  `SGD_MU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // Once clearing is over, ready only drops for a stuck result register.
  `SGD_MU_ASSERT_NOW(a_ready_follows_out, clk, rst, $past(in_ready) && !$past(rst), in_ready == (!out_valid || out_ready), "input ready out of step with result side")

endmodule

bind sgd_momentum_update_core sgd_mu_checker u_sgd_mu_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (request.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_data (result.data)
);

### dv/tb.sv
// Testbench for the SGD momentum update core: directed and random items checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Run the core with its default velocity store, which covers the whole index range.
  localparam int unsigned VEL_DEPTH = sgd_mu_pkg::VELOCITY_DEPTH_DEFAULT;

  localparam int RANDOM_SETTINGS = 8;
  localparam int ITEMS_PER_SETTING = 110;
  // Slack after the last result: the pipeline is nine stages deep.
  localparam int SETTLE_CYCLES = 12;
  // The clearing pass and about 900 items with the longest gaps and stalls take far less.
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [sgd_mu_pkg::INDEX_W-1:0] index;
    sgd_mu_pkg::out_item_t          update;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                               cfg_write_en;
  logic [sgd_mu_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sgd_mu_pkg::CFG_DATA_W-1:0]  cfg_data;

  sgd_mu_stream_if #(.data_t(sgd_mu_pkg::in_item_t))  req_if ();
  sgd_mu_stream_if #(.data_t(sgd_mu_pkg::out_item_t)) res_if ();

  sgd_momentum_update_core #(
    .VELOCITY_DEPTH(VEL_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .request     (req_if),
    .result      (res_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the register file and of the velocity store, as the core should hold them.
  logic [sgd_mu_pkg::FACTOR_W-1:0] cfg_lr;
  logic [sgd_mu_pkg::FACTOR_W-1:0] cfg_momentum;
  logic [sgd_mu_pkg::FACTOR_W-1:0] cfg_dampening;
  logic [sgd_mu_pkg::FACTOR_W-1:0] cfg_decay;
  logic                            cfg_nesterov;
  sgd_mu_pkg::fix_t                vel_shadow [VEL_DEPTH];

  pending_t pending_updates [$];
  pending_t head;

  int error_count = 0;
  int checked_count = 0;
  int items_sent = 0;
  int beyond_count = 0;
  int settings_count = 0;
  int cycle_count = 0;
  int tx_quiet = 0;
  int rx_quiet = 0;
  int rx_stall = 0;
  logic [sgd_mu_pkg::INDEX_W-1:0] last_index = '0;

  // ---------------------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------------------

  // Clamp a wide intermediate into signed Q16.16.
  function automatic sgd_mu_pkg::fix_t clamp_q16(input longint x);
    if (x > longint'(sgd_mu_pkg::FIX_MAX)) return sgd_mu_pkg::FIX_MAX;
    if (x < longint'(sgd_mu_pkg::FIX_MIN)) return sgd_mu_pkg::FIX_MIN;
    return sgd_mu_pkg::fix_t'(x);
  endfunction

  // Q16.16 times an unsigned 16-fraction-bit factor: exact product, add half an LSB,
  // arithmetic shift (floor), then clamp.
  function automatic sgd_mu_pkg::fix_t mul_q16(input sgd_mu_pkg::fix_t a,
                                               input sgd_mu_pkg::factor_t f);
    longint p;
    p = longint'(a) * longint'(f) + 64'sd32768;
    return clamp_q16(p >>> 16);
  endfunction

  // Work out the weight and velocity that one item must produce and update the shadow store.
  function automatic pending_t predict_update(input sgd_mu_pkg::in_item_t it);
    pending_t         res;
    sgd_mu_pkg::fix_t grad;
    sgd_mu_pkg::fix_t v_old;
    sgd_mu_pkg::fix_t v_new;
    sgd_mu_pkg::fix_t step;
    logic             in_store;
    in_store = it.element_index < VEL_DEPTH;
    v_old = in_store ? vel_shadow[it.element_index] : '0;
    grad = clamp_q16(longint'(it.gradient_value) +
                     longint'(mul_q16(it.weight_value, {1'b0, cfg_decay})));
    if (cfg_momentum != '0) begin
      v_new = clamp_q16(longint'(mul_q16(v_old, {1'b0, cfg_momentum})) +
                        longint'(mul_q16(grad,
                                         sgd_mu_pkg::FACTOR_ONE - {1'b0, cfg_dampening})));
      if (in_store) vel_shadow[it.element_index] = v_new;
      if (cfg_nesterov) begin
        step = clamp_q16(longint'(grad) + longint'(mul_q16(v_new, {1'b0, cfg_momentum})));
      end else begin
        step = v_new;
      end
    end else begin
      // Momentum off: the entry is neither used nor written, only reported.
      v_new = v_old;
      step = grad;
    end
    res.index = it.element_index;
    res.update.new_weight = clamp_q16(longint'(it.weight_value) -
                                      longint'(mul_q16(step, {1'b0, cfg_lr})));
    res.update.new_velocity = v_new;
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------------------

  // Length of a pause in cycles: mostly none or short, a few long, and now and then a quiet
  // stretch with no pauses at all.
  function automatic int pick_pause(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Q16.16 operand: small magnitudes, full random words, and the corner values.
  function automatic sgd_mu_pkg::fix_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return sgd_mu_pkg::fix_t'(int'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
    end
    if (r < 70) return sgd_mu_pkg::fix_t'($urandom());
    case ($urandom_range(0, 6))
      0: return sgd_mu_pkg::FIX_MAX;
      1: return sgd_mu_pkg::FIX_MIN;
      2: return 32'sh0000_0000;
      3: return -32'sh1;
      4: return 32'sh1;
      5: return 32'sh0001_0000;
      default: return 32'shFFFF_0000;
    endcase
  endfunction

  // Index: favor a few hot entries and repeats so that back-to-back updates of one entry
  // exercise the forwarding path; spread the rest over the whole index range.
  function automatic logic [sgd_mu_pkg::INDEX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 10) begin
      if (r < 65) last_index = sgd_mu_pkg::INDEX_W'($urandom_range(0, 15));
      else if (r < 85) last_index = sgd_mu_pkg::INDEX_W'($urandom_range(0, VEL_DEPTH - 1));
      else last_index = sgd_mu_pkg::INDEX_W'($urandom_range(0, 2**sgd_mu_pkg::INDEX_W - 1));
    end
    return last_index;
  endfunction

  function automatic logic [sgd_mu_pkg::FACTOR_W-1:0] pick_factor();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 35) return '1;
    if (r < 42) return sgd_mu_pkg::FACTOR_W'(1);
    return sgd_mu_pkg::FACTOR_W'($urandom_range(0, 2**sgd_mu_pkg::FACTOR_W - 1));
  endfunction

  function automatic sgd_mu_pkg::in_item_t make_item(input int unsigned idx,
                                                     input sgd_mu_pkg::fix_t w,
                                                     input sgd_mu_pkg::fix_t g);
    sgd_mu_pkg::in_item_t it;
    it.element_index = sgd_mu_pkg::INDEX_W'(idx);
    it.weight_value = w;
    it.gradient_value = g;
    return it;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Drivers. Every task starts and ends just after a falling edge.
  // ---------------------------------------------------------------------------------------

  // Write one register and mirror it in the shadow; bits above the width and unknown
  // indexes drop out here just as they must in the core.
  task automatic write_reg(input logic [sgd_mu_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sgd_mu_pkg::CFG_DATA_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    case (idx)
      sgd_mu_pkg::REG_LEARNING_RATE:    cfg_lr = val[sgd_mu_pkg::FACTOR_W-1:0];
      sgd_mu_pkg::REG_MOMENTUM_FACTOR:  cfg_momentum = val[sgd_mu_pkg::FACTOR_W-1:0];
      sgd_mu_pkg::REG_DAMPENING_FACTOR: cfg_dampening = val[sgd_mu_pkg::FACTOR_W-1:0];
      sgd_mu_pkg::REG_DECAY_FACTOR:     cfg_decay = val[sgd_mu_pkg::FACTOR_W-1:0];
      sgd_mu_pkg::REG_NESTEROV_ENABLE:  cfg_nesterov = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [sgd_mu_pkg::FACTOR_W-1:0] lr,
                           input logic [sgd_mu_pkg::FACTOR_W-1:0] mom,
                           input logic [sgd_mu_pkg::FACTOR_W-1:0] damp,
                           input logic [sgd_mu_pkg::FACTOR_W-1:0] decay,
                           input logic [sgd_mu_pkg::CFG_DATA_W-1:0] nest);
    write_reg(sgd_mu_pkg::REG_LEARNING_RATE, lr);
    write_reg(sgd_mu_pkg::REG_MOMENTUM_FACTOR, mom);
    write_reg(sgd_mu_pkg::REG_DAMPENING_FACTOR, damp);
    write_reg(sgd_mu_pkg::REG_DECAY_FACTOR, decay);
    write_reg(sgd_mu_pkg::REG_NESTEROV_ENABLE, nest);
    settings_count++;
  endtask

  // Offer one item after a random gap, hold it until taken, then predict its result.
  task automatic send_item(input sgd_mu_pkg::in_item_t item_in);
    int gap;
    gap = pick_pause(tx_quiet);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item_in;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_updates.push_back(predict_update(item_in));
    items_sent++;
    if (item_in.element_index >= VEL_DEPTH) beyond_count++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result is back; registers may change after.
  task automatic drain_pipeline();
    req_if.valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: random back-pressure and the comparison against the oldest prediction
  // ---------------------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      res_if.ready <= 1'b0;
      rx_stall--;
    end else begin
      res_if.ready <= 1'b1;
      rx_stall = pick_pause(rx_quiet);
    end
  end

  task automatic report_mismatch(input string what,
                                 input logic [sgd_mu_pkg::INDEX_W-1:0] idx,
                                 input sgd_mu_pkg::fix_t got, input sgd_mu_pkg::fix_t want);
    error_count++;
    if (error_count <= 40) begin
      $display("mismatch: %s, index %0d, cycle %0d: got 0x%08h, want 0x%08h",
               what, idx, cycle_count, got, want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("result with no item pending", '0, res_if.data.new_weight, '0);
      end else begin
        head = pending_updates.pop_front();
        checked_count++;
        if (res_if.data.new_weight !== head.update.new_weight) begin
          report_mismatch("new_weight", head.index, res_if.data.new_weight,
                          head.update.new_weight);
        end
        if (res_if.data.new_velocity !== head.update.new_velocity) begin
          report_mismatch("new_velocity", head.index, res_if.data.new_velocity,
                          head.update.new_velocity);
        end
      end
    end
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_updates.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Leave the registers at their reset values: momentum off, the default learning rate.
  task automatic test_reset_defaults();
    send_item(make_item(0, sgd_mu_pkg::FIX_MAX, sgd_mu_pkg::FIX_MIN));
    send_item(make_item(5, -32'sh1, 32'sh1));
    send_item(make_item(4095, sgd_mu_pkg::FIX_MIN, sgd_mu_pkg::FIX_MAX));
    send_item(make_item(7, 32'sh0001_0000, 32'sh0001_0000));
  endtask

  // Push every factor but dampening, which stays zero, to its top and hit the same entry back
  // to back, the last entry of the store, the first entry and the top of the index range.
  task automatic test_field_extremes();
    drain_pipeline();
    write_all('1, '1, '0, '1, 16'hFFFF);
    send_item(make_item(1, sgd_mu_pkg::FIX_MAX, sgd_mu_pkg::FIX_MAX));
    send_item(make_item(1, sgd_mu_pkg::FIX_MIN, sgd_mu_pkg::FIX_MIN));
    send_item(make_item(1, sgd_mu_pkg::FIX_MAX, sgd_mu_pkg::FIX_MIN));
    send_item(make_item(VEL_DEPTH - 1, sgd_mu_pkg::FIX_MIN, sgd_mu_pkg::FIX_MAX));
    send_item(make_item(0, sgd_mu_pkg::FIX_MAX, sgd_mu_pkg::FIX_MAX));
    send_item(make_item(4095, -32'sh1, -32'sh1));
    send_item(make_item(0, 32'sh0, 32'sh0));
  endtask

  // Unknown indexes must change nothing; the enable register keeps only its low bit.
  task automatic test_register_masking();
    int k;
    drain_pipeline();
    for (k = sgd_mu_pkg::REG_NESTEROV_ENABLE + 1; k < 2**sgd_mu_pkg::CFG_INDEX_W; k++) begin
      write_reg(sgd_mu_pkg::CFG_INDEX_W'(k), 16'hFFFF);
    end
    write_all(16'd1, 16'h8000, '1, '0, 16'hFFFE);
    send_item(make_item(1, 32'sh0000_3039, 32'sh0001_0000));
    send_item(make_item(1, -32'sh0003_0000, 32'sh7FFF_0000));
    send_item(make_item(2, 32'sh1, -32'sh1));
  endtask

  // Momentum off with Nesterov on: the stored entry is only reported, never touched.
  task automatic test_momentum_off();
    drain_pipeline();
    write_all(16'h8000, '0, 16'h1234, 16'h0100, 16'h0001);
    send_item(make_item(1, 32'sh0002_0000, -32'sh0001_8000));
    send_item(make_item(2, sgd_mu_pkg::FIX_MIN, sgd_mu_pkg::FIX_MIN));
    send_item(make_item(VEL_DEPTH - 5, sgd_mu_pkg::FIX_MAX, -32'sh1));
  endtask

  // Random items under a run of settings: all factors but dampening high, all zero, heavy
  // damping, then random settings with random junk above the enable bit.
  task automatic test_random_mix();
    int phase;
    int n;
    for (phase = 0; phase < RANDOM_SETTINGS; phase++) begin
      drain_pipeline();
      case (phase)
        0: write_all('1, '1, '0, '1, 16'h0001);
        1: write_all('0, '0, '0, '0,
                     sgd_mu_pkg::CFG_DATA_W'($urandom_range(0, 2**sgd_mu_pkg::CFG_DATA_W - 1)));
        2: write_all(16'd1, '1, '1, '0, 16'h0000);
        default: begin
          write_all(pick_factor(), pick_factor(), pick_factor(), pick_factor(),
                    sgd_mu_pkg::CFG_DATA_W'($urandom_range(0, 2**sgd_mu_pkg::CFG_DATA_W - 1)));
        end
      endcase
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        send_item(make_item(pick_index(), pick_value(), pick_value()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
    cfg_lr        = sgd_mu_pkg::LEARNING_RATE_RESET;
    cfg_momentum  = '0;
    cfg_dampening = '0;
    cfg_decay     = '0;
    cfg_nesterov  = 1'b0;
    foreach (vel_shadow[i]) vel_shadow[i] = '0;

    // Hold reset at the start, release it on a falling edge.
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The core clears its store first and holds ready low; send_item simply waits.
    test_reset_defaults();
    test_field_extremes();
    test_register_masking();
    test_momentum_off();
    test_random_mix();

    drain_pipeline();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items under %0d register settings, %0d results compared",
             items_sent, settings_count + 1, checked_count);
    $display("%0d items addressed entries beyond the %0d-entry store, %0d mismatches",
             beyond_count, VEL_DEPTH, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
